// File: rtl/mexp_pkg.sv
// Shared types, constants and helper functions for the modular exponentiation block.
// Used by mexp_ctrl, mexp_datapath and modular_exponentiation; depends on nothing else.
`default_nettype none

package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [1:0]       cfg_index_t;

    localparam cnt_t CNT_LAST = cnt_t'(WIDTH - 1);

    localparam cfg_index_t REG_MODULUS  = 2'd0;
    localparam cfg_index_t REG_EXPONENT = 2'd1;

    localparam word_t MODULUS_RESET  = word_t'(3233);
    localparam word_t EXPONENT_RESET = word_t'(17);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MINIT,
        ST_MSTEP,
        ST_MCOMMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic reduce_step;
        logic mul_init;
        logic mul_step;
        logic mul_commit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic special;
    } status_t;

    // Sum of two residues below m, reduced once more below m.
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block; uses mexp_pkg, mexp_ctrl and mexp_datapath.
// After acceptance the block runs 32 reduction steps, then per exponent bit a set-up step, 32
// multiplier steps and a commit step, then loads the output register; a zero modulus or exponent
// goes straight to loading the output register. A new word is taken only after the last one has
// been loaded there, later while a finished word waits. Reset is asynchronous and active low; it
// sets modulus 3233 and exponent 17 and empties the block.
`default_nettype none

module modular_exponentiation (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire mexp_pkg::word_t       message,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output mexp_pkg::word_t            power_result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire mexp_pkg::cfg_index_t  cfg_index,
    input  wire mexp_pkg::word_t       cfg_data
);

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mexp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .message      (message),
        .cmd          (cmd),
        .status       (status),
        .power_result (power_result)
    );

endmodule

`default_nettype wire

// File: rtl/mexp_ctrl.sv
// Controller state machine of the modular exponentiation block.
// Sequences base reduction and the square-and-multiply passes; uses mexp_pkg.
`default_nettype none

module mexp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire mexp_pkg::status_t  status,
    output mexp_pkg::cmd_t          cmd
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;
    mexp_pkg::cnt_t   step_cnt_reg;
    mexp_pkg::cnt_t   step_cnt_next;
    mexp_pkg::cnt_t   bit_cnt_reg;
    mexp_pkg::cnt_t   bit_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             release_ok;

    assign accept     = in_valid && (state_reg == mexp_pkg::ST_IDLE);
    assign release_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                step_cnt_next = '0;
                bit_cnt_next  = '0;
                if (accept)
                begin
                    state_next = status.special ? mexp_pkg::ST_FINISH : mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == mexp_pkg::CNT_LAST)
                begin
                    state_next = mexp_pkg::ST_MINIT;
                end
            end
            mexp_pkg::ST_MINIT:
            begin
                step_cnt_next = '0;
                state_next    = mexp_pkg::ST_MSTEP;
            end
            mexp_pkg::ST_MSTEP:
            begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == mexp_pkg::CNT_LAST)
                begin
                    state_next = mexp_pkg::ST_MCOMMIT;
                end
            end
            mexp_pkg::ST_MCOMMIT:
            begin
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == mexp_pkg::CNT_LAST)
                begin
                    state_next = mexp_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = mexp_pkg::ST_MINIT;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (release_ok)
                begin
                    state_next = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:    cmd.load        = accept;
            mexp_pkg::ST_REDUCE:  cmd.reduce_step = 1'b1;
            mexp_pkg::ST_MINIT:   cmd.mul_init    = 1'b1;
            mexp_pkg::ST_MSTEP:   cmd.mul_step    = 1'b1;
            mexp_pkg::ST_MCOMMIT: cmd.mul_commit  = 1'b1;
            mexp_pkg::ST_FINISH:
            begin
                cmd.finish = release_ok;
                if (release_ok)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            step_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == mexp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/mexp_datapath.sv
// Datapath of the modular exponentiation block: configuration registers, base reducer,
// two shift-and-add modular multipliers and the result register. Uses mexp_pkg.
`default_nettype none

module mexp_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire mexp_pkg::cfg_index_t  cfg_index,
    input  wire mexp_pkg::word_t       cfg_data,
    input  wire mexp_pkg::word_t       message,
    input  wire mexp_pkg::cmd_t        cmd,
    output mexp_pkg::status_t          status,
    output mexp_pkg::word_t            power_result
);

    mexp_pkg::word_t modulus_reg;
    mexp_pkg::word_t modulus_next;
    mexp_pkg::word_t exponent_reg;
    mexp_pkg::word_t exponent_next;
    mexp_pkg::word_t msg_reg;
    mexp_pkg::word_t msg_next;
    mexp_pkg::word_t base_reg;
    mexp_pkg::word_t base_next;
    mexp_pkg::word_t acc_reg;
    mexp_pkg::word_t acc_next;
    mexp_pkg::word_t exp_reg;
    mexp_pkg::word_t exp_next;
    mexp_pkg::word_t bbits_reg;
    mexp_pkg::word_t bbits_next;
    mexp_pkg::word_t ma_reg;
    mexp_pkg::word_t ma_next;
    mexp_pkg::word_t mp_reg;
    mexp_pkg::word_t mp_next;
    mexp_pkg::word_t sa_reg;
    mexp_pkg::word_t sa_next;
    mexp_pkg::word_t sp_reg;
    mexp_pkg::word_t sp_next;
    mexp_pkg::word_t result_reg;
    mexp_pkg::word_t result_next;
    logic [mexp_pkg::WIDTH:0] rem_shift;

    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                mexp_pkg::REG_MODULUS:  modulus_next  = cfg_data;
                mexp_pkg::REG_EXPONENT: exponent_next = cfg_data;
                default:
                begin
                    modulus_next = modulus_reg;
                end
            endcase
        end
    end

    assign status.special = (modulus_reg == '0) || (exponent_reg == '0);

    // One restoring step of message modulo modulus, most significant bit first.
    assign rem_shift = {base_reg, msg_reg[mexp_pkg::WIDTH-1]};

    always_comb
    begin
        msg_next    = msg_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        exp_next    = exp_reg;
        bbits_next  = bbits_reg;
        ma_next     = ma_reg;
        mp_next     = mp_reg;
        sa_next     = sa_reg;
        sp_next     = sp_reg;
        result_next = result_reg;
        if (cmd.load)
        begin
            msg_next  = message;
            base_next = '0;
            acc_next  = (modulus_reg == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);
            exp_next  = exponent_reg;
        end
        if (cmd.reduce_step)
        begin
            msg_next = {msg_reg[mexp_pkg::WIDTH-2:0], 1'b0};
            if (rem_shift >= {1'b0, modulus_reg})
            begin
                base_next = mexp_pkg::word_t'(rem_shift - {1'b0, modulus_reg});
            end
            else
            begin
                base_next = rem_shift[mexp_pkg::WIDTH-1:0];
            end
        end
        if (cmd.mul_init)
        begin
            ma_next    = acc_reg;
            mp_next    = '0;
            sa_next    = base_reg;
            sp_next    = '0;
            bbits_next = base_reg;
        end
        if (cmd.mul_step)
        begin
            if (bbits_reg[0])
            begin
                mp_next = mexp_pkg::add_mod(mp_reg, ma_reg, modulus_reg);
                sp_next = mexp_pkg::add_mod(sp_reg, sa_reg, modulus_reg);
            end
            ma_next    = mexp_pkg::add_mod(ma_reg, ma_reg, modulus_reg);
            sa_next    = mexp_pkg::add_mod(sa_reg, sa_reg, modulus_reg);
            bbits_next = {1'b0, bbits_reg[mexp_pkg::WIDTH-1:1]};
        end
        if (cmd.mul_commit)
        begin
            if (exp_reg[0])
            begin
                acc_next = mp_reg;
            end
            base_next = sp_reg;
            exp_next  = {1'b0, exp_reg[mexp_pkg::WIDTH-1:1]};
        end
        if (cmd.finish)
        begin
            if (modulus_reg == '0)
            begin
                result_next = '0;
            end
            else if (exponent_reg == '0)
            begin
                result_next = mexp_pkg::word_t'(1);
            end
            else
            begin
                result_next = acc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= mexp_pkg::MODULUS_RESET;
            exponent_reg <= mexp_pkg::EXPONENT_RESET;
        end
        else
        begin
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg    <= msg_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        exp_reg    <= exp_next;
        bbits_reg  <= bbits_next;
        ma_reg     <= ma_next;
        mp_reg     <= mp_next;
        sa_reg     <= sa_next;
        sp_reg     <= sp_next;
        result_reg <= result_next;
    end

    assign power_result = result_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_modular_exponentiation.sv
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation: predicts each message to the power
// exponent, mod modulus, and compares every result word in order of arrival.
// Depends on mexp_pkg and the modular_exponentiation RTL only.

module tb_modular_exponentiation;

    localparam int                   QUIET_LIMIT   = 12000;
    localparam int                   PHASE_ITEMS   = 175;
    localparam int                   ITEMS_PER_SET = 30;
    localparam int                   STALL_CYCLES  = 3000;
    localparam mexp_pkg::cfg_index_t REG_SPARE_LO  = 2'd2;
    localparam mexp_pkg::cfg_index_t REG_SPARE_HI  = 2'd3;

    typedef logic [2*mexp_pkg::WIDTH-1:0] dword_t;

    typedef struct {
        mexp_pkg::word_t message;
        mexp_pkg::word_t power;
    } pending_power_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    mexp_pkg::word_t      message;
    logic                 out_valid;
    logic                 out_ready;
    mexp_pkg::word_t      power_result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    mexp_pkg::cfg_index_t cfg_index;
    mexp_pkg::word_t      cfg_data;

    mexp_pkg::word_t modulus_setting;
    mexp_pkg::word_t exponent_setting;
    pending_power_t  pending_powers[$];
    pending_power_t  oldest_power;
    int              tx_idle_pct;
    int              rx_idle_pct;
    int              stall_request;
    int              stall_left;
    int              quiet_cycles;
    int              mismatch_count;
    int              messages_sent;
    int              words_checked;
    int              register_writes;

    modular_exponentiation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message      (message),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic mexp_pkg::word_t predict_power(input mexp_pkg::word_t msg,
                                                      input mexp_pkg::word_t m,
                                                      input mexp_pkg::word_t e);
        dword_t base;
        dword_t acc;
        if (m == '0)
        begin
            return '0;
        end
        if (e == '0)
        begin
            return mexp_pkg::word_t'(1);
        end
        base = dword_t'(msg) % dword_t'(m);
        acc  = dword_t'(1) % dword_t'(m);
        for (int i = 0; i < mexp_pkg::WIDTH; i++)
        begin
            if (e[i])
            begin
                acc = (acc * base) % dword_t'(m);
            end
            base = (base * base) % dword_t'(m);
        end
        return mexp_pkg::word_t'(acc);
    endfunction

    function automatic mexp_pkg::word_t pick_modulus();
        int kind;
        kind = $urandom_range(99);
        if (kind < 3)
        begin
            return '0;
        end
        else if (kind < 8)
        begin
            return mexp_pkg::word_t'(1);
        end
        else if (kind < 14)
        begin
            return '1;
        end
        else if (kind < 30)
        begin
            return mexp_pkg::word_t'($urandom_range(255, 2));
        end
        else if (kind < 45)
        begin
            return mexp_pkg::word_t'($urandom_range(65535, 256));
        end
        else if (kind < 60)
        begin
            return mexp_pkg::word_t'($urandom) | mexp_pkg::word_t'(1)
                   | (mexp_pkg::word_t'(1) << (mexp_pkg::WIDTH - 1));
        end
        return mexp_pkg::word_t'($urandom);
    endfunction

    function automatic mexp_pkg::word_t pick_exponent();
        int kind;
        kind = $urandom_range(99);
        if (kind < 6)
        begin
            return '0;
        end
        else if (kind < 10)
        begin
            return mexp_pkg::word_t'(1);
        end
        else if (kind < 14)
        begin
            return mexp_pkg::word_t'(65537);
        end
        else if (kind < 20)
        begin
            return '1;
        end
        else if (kind < 35)
        begin
            return mexp_pkg::word_t'($urandom_range(255, 2));
        end
        return mexp_pkg::word_t'($urandom);
    endfunction

    function automatic mexp_pkg::word_t pick_message();
        int kind;
        kind = $urandom_range(99);
        if (kind < 4)
        begin
            return '0;
        end
        else if (kind < 8)
        begin
            return '1;
        end
        else if (kind < 13)
        begin
            return modulus_setting - mexp_pkg::word_t'(1);
        end
        else if (kind < 17)
        begin
            return modulus_setting;
        end
        else if (kind < 22)
        begin
            return modulus_setting + mexp_pkg::word_t'($urandom_range(255));
        end
        return mexp_pkg::word_t'($urandom);
    endfunction

    task automatic send_message(input mexp_pkg::word_t msg);
        pending_power_t entry;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        message  <= msg;
        do
            @(posedge clk);
        while (!in_ready);
        entry.message = msg;
        entry.power   = predict_power(msg, modulus_setting, exponent_setting);
        pending_powers.push_back(entry);
        messages_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_powers.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input mexp_pkg::cfg_index_t idx, input mexp_pkg::word_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == mexp_pkg::REG_MODULUS)
        begin
            modulus_setting = value;
        end
        else if (idx == mexp_pkg::REG_EXPONENT)
        begin
            exponent_setting = value;
        end
        register_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input mexp_pkg::word_t m, input mexp_pkg::word_t e);
        wait_for_results();
        write_register(mexp_pkg::REG_MODULUS, m);
        write_register(mexp_pkg::REG_EXPONENT, e);
    endtask

    task automatic test_reset_defaults();
        send_message('0);
        send_message(mexp_pkg::word_t'(1));
        send_message(mexp_pkg::word_t'(65));
        send_message(mexp_pkg::word_t'(3232));
        send_message(mexp_pkg::word_t'(3233));
        send_message('1);
    endtask

    task automatic test_spare_indexes();
        wait_for_results();
        write_register(REG_SPARE_LO, mexp_pkg::word_t'(32'h5555_AAAA));
        write_register(REG_SPARE_HI, mexp_pkg::word_t'(32'hAAAA_5555));
        send_message(mexp_pkg::word_t'(123));
    endtask

    task automatic test_full_width();
        set_registers('1, '1);
        send_message('1 - mexp_pkg::word_t'(1));
        send_message('1);
        send_message('0);
        send_message(mexp_pkg::word_t'(2));
        set_registers(mexp_pkg::word_t'(32'hFFFF_FFFB), mexp_pkg::word_t'(32'h8000_0001));
        send_message(mexp_pkg::word_t'(32'hDEAD_BEEF));
    endtask

    task automatic test_degenerate_settings();
        set_registers(mexp_pkg::word_t'(1), '0);
        send_message(mexp_pkg::word_t'(5));
        set_registers(mexp_pkg::word_t'(1), mexp_pkg::word_t'(5));
        send_message(mexp_pkg::word_t'(7));
        set_registers(mexp_pkg::word_t'(32'h1234_5679), '0);
        send_message('0);
        set_registers('0, '0);
        send_message(mexp_pkg::word_t'(9));
        set_registers('0, mexp_pkg::word_t'(3));
        send_message('1);
    endtask

    task automatic test_inverse_pair();
        set_registers(mexp_pkg::word_t'(3233), mexp_pkg::word_t'(2753));
        send_message(mexp_pkg::word_t'(2790));
        set_registers(mexp_pkg::word_t'(1000), mexp_pkg::word_t'(1));
        send_message(mexp_pkg::word_t'(32'hFFFF_0000));
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_registers(mexp_pkg::word_t'($urandom) | mexp_pkg::word_t'(1), mexp_pkg::word_t'(3));
        stall_request = STALL_CYCLES;
        for (int k = 0; k < 8; k++)
        begin
            send_message(pick_message());
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            if (k % ITEMS_PER_SET == 0)
            begin
                set_registers(pick_modulus(), pick_exponent());
            end
            send_message(pick_message());
        end
        wait_for_results();
    endtask

    always @(negedge clk)
    begin
        if (stall_request != 0)
        begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_powers.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, actual %h", $time, power_result);
                mismatch_count++;
            end
            else
            begin
                oldest_power = pending_powers.pop_front();
                words_checked++;
                if (power_result !== oldest_power.power)
                begin
                    $display("%0t ns: power_result for message %h: expected %h, actual %h",
                             $time, oldest_power.message, oldest_power.power, power_result);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d cycles without a handshake.", quiet_cycles);
            $display("modular_exponentiation regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        message          = '0;
        out_ready        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = mexp_pkg::REG_MODULUS;
        cfg_data         = '0;
        modulus_setting  = mexp_pkg::MODULUS_RESET;
        exponent_setting = mexp_pkg::EXPONENT_RESET;
        tx_idle_pct      = 0;
        rx_idle_pct      = 0;
        stall_request    = 0;
        stall_left       = 0;
        quiet_cycles     = 0;
        mismatch_count   = 0;
        messages_sent    = 0;
        words_checked    = 0;
        register_writes  = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_spare_indexes();
        test_full_width();
        test_degenerate_settings();
        test_inverse_pair();
        test_random_traffic(12, 54);
        test_random_traffic(54, 12);
        test_output_stall();
        test_random_traffic(0, 0);

        wait_for_results();
        repeat (1200) @(posedge clk);
        $display("Checked %0d of %0d message words across %0d register writes.",
                 words_checked, messages_sent, register_writes);
        $display("Included reset values, full-width, unit and zero moduli, zero exponents, ",
                 "ignored indexes and a long output stall.");
        if (mismatch_count == 0 && pending_powers.size() == 0)
        begin
            $display("modular_exponentiation regression: pass");
        end
        else
        begin
            $display("modular_exponentiation regression: fail");
        end
        $finish;
    end

endmodule
